// File: rtl/ssfb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssfb_pkg
// Shared types, command codes and constants of the seven-segment frame builder.
// ----------------------------------------------------------------------------
package ssfb_pkg;

  // input command codes
  localparam logic [3:0] CMD_DIGIT   = 4'd0;
  localparam logic [3:0] CMD_DECIMAL = 4'd1;
  localparam logic [3:0] CMD_COLON   = 4'd2;
  localparam logic [3:0] CMD_DOTS    = 4'd3;
  localparam logic [3:0] CMD_CLOCK   = 4'd4;
  localparam logic [3:0] CMD_NUMBER  = 4'd5;
  localparam logic [3:0] CMD_CLEAR   = 4'd6;
  localparam logic [3:0] CMD_FILL    = 4'd7;
  localparam logic [3:0] CMD_FLUSH   = 4'd8;
  localparam logic [3:0] CMD_BRIGHT  = 4'd9;
  localparam logic [3:0] CMD_BLINK   = 4'd10;
  localparam logic [3:0] CMD_INIT    = 4'd11;

  // operations handed from the front to the back
  typedef enum logic [3:0] {
    OP_DIGIT,
    OP_DECIMAL,
    OP_COLON,
    OP_DOTS,
    OP_SHOW,
    OP_CLEAR,
    OP_FILL,
    OP_FLUSH,
    OP_BRIGHT,
    OP_BLINK,
    OP_INIT
  } ssfb_op_t;

  typedef struct packed {
    ssfb_op_t        op;
    logic [2:0]      cell_sel;
    logic            flag;
    logic [2:0]      dots;
    logic [3:0][6:0] pat;
    logic [3:0]      level;
  } ssfb_entry_t;

  localparam logic [6:0] BASE_ADDR   = 7'h70;
  localparam logic [7:0] BYTE_INIT   = 8'h21;
  localparam logic [7:0] BYTE_BRIGHT = 8'hE0;
  localparam logic [7:0] BYTE_BLINK  = 8'h81;
  localparam logic [7:0] BYTE_PAD    = 8'h00;
  localparam logic [3:0] BRIGHT_MAX  = 4'd15;
  localparam logic [3:0] BLINK_MAX   = 4'd3;

  // cell layout
  localparam int COLON_CELL = 2;
  localparam int DP_BIT     = 7;
  localparam int COLON_BIT  = 1;
  localparam int DOT_LL_BIT = 3;
  localparam int DOT_UL_BIT = 2;
  localparam int DOT_UR_BIT = 4;

  // segments a..g in bits 0..6, blank for anything above nine
  function automatic logic [6:0] seg_pattern(input logic [7:0] value);
    logic [6:0] p;
    unique case (value)
      8'd0:    p = 7'h3F;
      8'd1:    p = 7'h06;
      8'd2:    p = 7'h5B;
      8'd3:    p = 7'h4F;
      8'd4:    p = 7'h66;
      8'd5:    p = 7'h6D;
      8'd6:    p = 7'h7D;
      8'd7:    p = 7'h07;
      8'd8:    p = 7'h7F;
      8'd9:    p = 7'h6F;
      default: p = 7'h00;
    endcase
    return p;
  endfunction

endpackage
`default_nettype wire

// File: rtl/ssfb_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssfb_front
// Takes one command beat, splits clock and number values into digits over a
// few steps and hands a decoded operation to the queue.
// ----------------------------------------------------------------------------
module ssfb_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [3:0]         command,
  input  logic [1:0]         digit_index,
  input  logic [7:0]         digit_value,
  input  logic               flag,
  input  logic [2:0]         dot_flags,
  input  logic [7:0]         hours,
  input  logic [7:0]         minutes,
  input  logic [15:0]        number,
  input  logic [7:0]         level,
  output logic               q_push,
  input  logic               q_full,
  output ssfb_pkg::ssfb_entry_t q_data
);
  import ssfb_pkg::*;

  typedef enum logic [4:0] {
    F_IDLE = 5'b00001,
    F_DIV  = 5'b00010,
    F_PAIR = 5'b00100,
    F_TENS = 5'b01000,
    F_PUT  = 5'b10000
  } front_state_t;

  front_state_t state, state_next;

  logic [3:0]  cmd;
  logic [1:0]  idx;
  logic [7:0]  dval;
  logic        flg;
  logic [2:0]  dots;
  logic [7:0]  hrs;
  logic [7:0]  mins;
  logic [15:0] num;
  logic [7:0]  lvl;
  logic [9:0]  q100;
  logic [7:0]  left;
  logic [7:0]  right;
  logic [4:0]  tens_l;
  logic [4:0]  tens_r;

  logic [33:0] div_prod;
  logic [15:0] rem100;
  logic [15:0] prod_l;
  logic [15:0] prod_r;
  logic [7:0]  unit_l;
  logic [7:0]  unit_r;
  logic        op_ok;
  logic        accept;
  ssfb_entry_t entry;

  assign accept = push && !full;
  assign full   = (state != F_IDLE);

  // num / 100 by reciprocal, exact over 16 bits
  assign div_prod = 34'(num) * 34'd167773;
  assign rem100   = num - 16'(q100) * 16'd100;
  // v / 10 by reciprocal, exact over 8 bits
  assign prod_l   = 16'(left) * 16'd205;
  assign prod_r   = 16'(right) * 16'd205;
  assign unit_l   = left - 8'(tens_l) * 8'd10;
  assign unit_r   = right - 8'(tens_r) * 8'd10;

  always_comb begin
    entry          = '0;
    op_ok          = 1'b1;
    entry.cell_sel = (idx > 2'd1) ? ({1'b0, idx} + 3'd1) : {1'b0, idx};
    entry.flag     = flg;
    entry.dots     = dots;
    entry.pat[0] = seg_pattern({3'b0, tens_l});
    entry.pat[1] = seg_pattern({4'b0, unit_l[3:0]});
    entry.pat[2] = seg_pattern({3'b0, tens_r});
    entry.pat[3] = seg_pattern({4'b0, unit_r[3:0]});
    entry.level = '0;
    entry.op    = OP_CLEAR;
    unique case (cmd)
      CMD_DIGIT: begin
        entry.op     = OP_DIGIT;
        entry.pat[0] = seg_pattern(dval);
      end
      CMD_DECIMAL: entry.op = OP_DECIMAL;
      CMD_COLON:   entry.op = OP_COLON;
      CMD_DOTS:    entry.op = OP_DOTS;
      CMD_CLOCK: begin
        entry.op   = OP_SHOW;
        entry.flag = 1'b1;
      end
      CMD_NUMBER: begin
        entry.op   = OP_SHOW;
        entry.flag = 1'b0;
      end
      CMD_CLEAR:   entry.op = OP_CLEAR;
      CMD_FILL:    entry.op = OP_FILL;
      CMD_FLUSH:   entry.op = OP_FLUSH;
      CMD_BRIGHT: begin
        entry.op    = OP_BRIGHT;
        entry.level = (lvl > 8'(BRIGHT_MAX)) ? BRIGHT_MAX : lvl[3:0];
      end
      CMD_BLINK: begin
        entry.op    = OP_BLINK;
        entry.level = (lvl > 8'(BLINK_MAX)) ? BLINK_MAX : {2'b0, lvl[1:0]};
      end
      CMD_INIT:    entry.op = OP_INIT;
      default:     op_ok = 1'b0;
    endcase
  end

  assign q_data = entry;
  assign q_push = (state == F_PUT) && op_ok && !q_full;

  always_comb begin
    state_next = state;
    unique case (state)
      F_IDLE: if (accept) state_next = F_DIV;
      F_DIV:  state_next = F_PAIR;
      F_PAIR: state_next = F_TENS;
      F_TENS: state_next = F_PUT;
      F_PUT:  if (!op_ok || !q_full) state_next = F_IDLE;
      default: state_next = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd  <= command;
      idx  <= digit_index;
      dval <= digit_value;
      flg  <= flag;
      dots <= dot_flags;
      hrs  <= hours;
      mins <= minutes;
      num  <= number;
      lvl  <= level;
    end
    if (state == F_DIV) begin
      q100 <= div_prod[33:24];
    end
    if (state == F_PAIR) begin
      // hundreds truncate to eight bits
      left  <= (cmd == CMD_CLOCK) ? hrs : q100[7:0];
      right <= (cmd == CMD_CLOCK) ? mins : rem100[7:0];
    end
    if (state == F_TENS) begin
      tens_l <= prod_l[15:11];
      tens_r <= prod_r[15:11];
    end
  end

endmodule
`default_nettype wire

// File: rtl/ssfb_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssfb_queue
// Short first-in first-out queue of decoded operations.
// ----------------------------------------------------------------------------
module ssfb_queue #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         wr_en,
  input  logic [W-1:0] wr_data,
  output logic         full,
  input  logic         rd_en,
  output logic [W-1:0] rd_data,
  output logic         empty
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_wr, do_rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule
`default_nettype wire

// File: rtl/ssfb_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssfb_back
// Holds the segment cells, applies edits and sequences the bus bytes of
// flush, brightness, blink and init into the output register.
// ----------------------------------------------------------------------------
module ssfb_back #(
  parameter int NUM_CELLS = 5
) (
  input  logic                  clk,
  input  logic                  rst,
  input  ssfb_pkg::ssfb_entry_t q_data,
  input  logic                  q_empty,
  output logic                  q_pop,
  input  logic                  cfg_we,
  input  logic [2:0]            cfg_wdata,
  input  logic                  pop,
  output logic                  empty,
  output logic [6:0]            bus_address,
  output logic [7:0]            data_byte,
  output logic                  end_of_transaction,
  output logic                  last
);
  import ssfb_pkg::*;

  localparam int CELL_W    = $clog2(NUM_CELLS);
  localparam int FLUSH_LEN = 2 * NUM_CELLS;
  localparam int CNT_W     = $clog2(FLUSH_LEN + 1);

  typedef enum logic [4:0] {
    B_IDLE   = 5'b00001,
    B_INIT   = 5'b00010,
    B_FLUSH  = 5'b00100,
    B_BRIGHT = 5'b01000,
    B_BLINK  = 5'b10000
  } back_state_t;

  back_state_t state, state_next;

  logic [7:0]        cells [NUM_CELLS];
  logic [CNT_W-1:0]  cnt;
  logic [CNT_W-1:0]  half;
  logic [CELL_W-1:0] rd_idx;
  logic [CELL_W-1:0] cidx;
  logic              in_init;
  logic [3:0]        lvl;
  logic [2:0]        offset;
  logic              out_valid;
  logic              can_load;
  logic              flush_end;
  logic              emit;
  logic [7:0]        emit_byte;
  logic              emit_eot;
  logic              emit_last;

  assign empty     = !out_valid;
  assign can_load  = !out_valid || pop;
  assign q_pop     = (state == B_IDLE) && !q_empty;
  assign cidx      = CELL_W'(q_data.cell_sel);
  // pad, then cell and pad pairs: odd counts carry a cell
  assign half      = cnt >> 1;
  assign rd_idx    = half[CELL_W-1:0];
  assign flush_end = (cnt == CNT_W'(FLUSH_LEN));

  always_comb begin
    state_next = state;
    emit       = 1'b0;
    emit_byte  = BYTE_PAD;
    emit_eot   = 1'b0;
    emit_last  = 1'b0;
    unique case (state)
      B_IDLE: begin
        if (!q_empty) begin
          unique case (q_data.op)
            OP_FLUSH:  state_next = B_FLUSH;
            OP_BRIGHT: state_next = B_BRIGHT;
            OP_BLINK:  state_next = B_BLINK;
            OP_INIT:   state_next = B_INIT;
            default:   state_next = B_IDLE;
          endcase
        end
      end
      B_INIT: begin
        if (can_load) begin
          emit       = 1'b1;
          emit_byte  = BYTE_INIT;
          emit_eot   = 1'b1;
          state_next = B_FLUSH;
        end
      end
      B_FLUSH: begin
        if (can_load) begin
          emit      = 1'b1;
          emit_byte = cnt[0] ? cells[rd_idx] : BYTE_PAD;
          emit_eot  = flush_end;
          emit_last = flush_end && !in_init;
          if (flush_end) state_next = in_init ? B_BRIGHT : B_IDLE;
        end
      end
      B_BRIGHT: begin
        if (can_load) begin
          emit       = 1'b1;
          emit_byte  = BYTE_BRIGHT | {4'b0, lvl};
          emit_eot   = 1'b1;
          emit_last  = !in_init;
          state_next = in_init ? B_BLINK : B_IDLE;
        end
      end
      B_BLINK: begin
        if (can_load) begin
          emit       = 1'b1;
          emit_byte  = BYTE_BLINK | {5'b0, lvl[1:0], 1'b0};
          emit_eot   = 1'b1;
          emit_last  = 1'b1;
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
      offset    <= '0;
      in_init   <= 1'b0;
      lvl       <= '0;
      cnt       <= '0;
      for (int i = 0; i < NUM_CELLS; i++) cells[i] <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) offset <= cfg_wdata;

      if (emit) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end

      if ((state == B_FLUSH) && emit) begin
        cnt <= flush_end ? '0 : cnt + 1'b1;
        if (flush_end && in_init) lvl <= BRIGHT_MAX;
      end
      if ((state == B_BRIGHT) && emit && in_init) begin
        lvl <= '0;
      end

      if ((state == B_INIT) && emit) begin
        for (int i = 0; i < NUM_CELLS; i++) cells[i] <= '0;
      end

      if (q_pop) begin
        in_init <= (q_data.op == OP_INIT);
        lvl     <= q_data.level;
        unique case (q_data.op)
          OP_DIGIT:   cells[cidx][6:0] <= q_data.pat[0];   // point kept
          OP_DECIMAL: cells[cidx][DP_BIT] <= q_data.flag;
          OP_COLON:   cells[COLON_CELL][COLON_BIT] <= q_data.flag;
          OP_DOTS: begin
            cells[COLON_CELL][DOT_LL_BIT] <= q_data.dots[0];
            cells[COLON_CELL][DOT_UL_BIT] <= q_data.dots[1];
            cells[COLON_CELL][DOT_UR_BIT] <= q_data.dots[2];
          end
          OP_SHOW: begin
            cells[0]          <= {1'b0, q_data.pat[0]};
            cells[1]          <= {1'b0, q_data.pat[1]};
            cells[COLON_CELL] <= 8'(q_data.flag) << COLON_BIT;
            cells[3]          <= {1'b0, q_data.pat[2]};
            cells[4]          <= {1'b0, q_data.pat[3]};
            // cells past the four digits and the colon go dark
            for (int i = 5; i < NUM_CELLS; i++) cells[i] <= '0;
          end
          OP_CLEAR: for (int i = 0; i < NUM_CELLS; i++) cells[i] <= 8'h00;
          OP_FILL:  for (int i = 0; i < NUM_CELLS; i++) cells[i] <= 8'hFF;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      bus_address        <= BASE_ADDR + {4'b0, offset};
      data_byte          <= emit_byte;
      end_of_transaction <= emit_eot;
      last               <= emit_last;
    end
  end

endmodule
`default_nettype wire

// File: rtl/seven_segment_frame_builder_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// seven_segment_frame_builder_unit
// Segment buffer and bus byte generator for a four-digit seven-segment module.
// ----------------------------------------------------------------------------
// the front steps through divide, pair, tens and put states on each command beat,
//   taking no new beat until its operation is queued or dropped; the back pops it
//   while idle, then loads its first byte; flush emits 2*NUM_CELLS+1 bytes, init
//   2*NUM_CELLS+4 bytes, one per cycle from the output register while pop keeps up
// reset: clears the segment cells, the address offset, the queue and the output
module seven_segment_frame_builder_unit #(
  parameter int NUM_CELLS   = 5,
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [3:0]  command,
  input  logic [1:0]  digit_index,
  input  logic [7:0]  digit_value,
  input  logic        flag,
  input  logic [2:0]  dot_flags,
  input  logic [7:0]  hours,
  input  logic [7:0]  minutes,
  input  logic [15:0] number,
  input  logic [7:0]  level,
  output logic        empty,
  input  logic        pop,
  output logic [6:0]  bus_address,
  output logic [7:0]  data_byte,
  output logic        end_of_transaction,
  output logic        last,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_wdata
);
  import ssfb_pkg::*;

  ssfb_entry_t wr_entry;
  ssfb_entry_t rd_entry;
  logic        q_push;
  logic        q_full;
  logic        q_pop;
  logic        q_empty;

  ssfb_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .command     (command),
    .digit_index (digit_index),
    .digit_value (digit_value),
    .flag        (flag),
    .dot_flags   (dot_flags),
    .hours       (hours),
    .minutes     (minutes),
    .number      (number),
    .level       (level),
    .q_push      (q_push),
    .q_full      (q_full),
    .q_data      (wr_entry)
  );

  ssfb_queue #(
    .W     ($bits(ssfb_entry_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_push),
    .wr_data (wr_entry),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_data (rd_entry),
    .empty   (q_empty)
  );

  ssfb_back #(
    .NUM_CELLS (NUM_CELLS)
  ) u_back (
    .clk                (clk),
    .rst                (rst),
    .q_data             (rd_entry),
    .q_empty            (q_empty),
    .q_pop              (q_pop),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .pop                (pop),
    .empty              (empty),
    .bus_address        (bus_address),
    .data_byte          (data_byte),
    .end_of_transaction (end_of_transaction),
    .last               (last)
  );

endmodule
`default_nettype wire

// File: rtl/ssfb_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssfb_checker
// Port-level checks of the frame builder, bound to the top level.
// ----------------------------------------------------------------------------
module ssfb_checker (
  input logic        clk,
  input logic        rst,
  input logic        push,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input logic [6:0]  bus_address,
  input logic [7:0]  data_byte,
  input logic        end_of_transaction,
  input logic        last
);

  // nothing waits at the output right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("output not empty after reset");

  // the front holds one command at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    push && !full |=> full)
    else $error("input not full after a command beat");

  // the last byte of a command always closes its transaction
  a_last_closes: assert property (@(posedge clk) disable iff (rst)
    !empty && last |-> end_of_transaction)
    else $error("last byte without end of transaction");

  a_address_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> bus_address[6:3] == 4'b1110)
    else $error("bus address outside its range");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(data_byte) && $stable(last))
    else $error("waiting result beat changed");

endmodule

bind seven_segment_frame_builder_unit ssfb_checker u_ssfb_checker (.*);
`default_nettype wire

// File: tb/seven_segment_frame_builder_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seven_segment_frame_builder_unit_test
// Self-checking bench for the seven-segment frame builder. A driver offers
// display commands from a pending queue, a predictor keeps its own segment
// buffer and address offset and lists the bus bytes each command must emit,
// and a monitor checks every popped beat against the oldest expected byte.
// Directed commands come first, then four random phases, each loading an
// address offset, with random gaps on both sides and one long output stall.
// ----------------------------------------------------------------------------
module seven_segment_frame_builder_unit_test;
  import ssfb_pkg::*;

  localparam int NUM_CELLS        = 5;
  localparam int SETTLE_CYCLES    = 24;
  localparam int RANDOM_PER_PHASE = 60;
  localparam int HOLD_AT          = 50;
  localparam int LONG_HOLD        = 300;
  localparam int MAX_REPORTS      = 10;
  localparam int TIMEOUT_NS       = 4_000_000;

  localparam logic [3:0] CMD_SPARE_TOP = 4'd15;

  // segment patterns a..g for the decimal digits
  localparam logic [6:0] GLYPHS [10] = '{
    7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
  };

  typedef struct {
    logic [3:0]  command;
    logic [1:0]  digit_index;
    logic [7:0]  digit_value;
    logic        flag;
    logic [2:0]  dot_flags;
    logic [7:0]  hours;
    logic [7:0]  minutes;
    logic [15:0] number;
    logic [7:0]  level;
  } cmd_item_t;

  typedef struct {
    logic [6:0] bus_address;
    logic [7:0] data_byte;
    logic       end_of_transaction;
    logic       last;
  } byte_beat_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [3:0]  command = '0;
  logic [1:0]  digit_index = '0;
  logic [7:0]  digit_value = '0;
  logic        flag = 1'b0;
  logic [2:0]  dot_flags = '0;
  logic [7:0]  hours = '0;
  logic [7:0]  minutes = '0;
  logic [15:0] number = '0;
  logic [7:0]  level = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [6:0]  bus_address;
  logic [7:0]  data_byte;
  logic        end_of_transaction;
  logic        last;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_wdata = '0;

  cmd_item_t  pending_cmds [$];
  byte_beat_t expected_bytes [$];
  byte_beat_t frame_bytes [$];

  logic [7:0] cell_model [NUM_CELLS];
  logic [2:0] offset_model;

  int cmds_offered = 0;
  int cmds_taken   = 0;
  int bytes_popped = 0;
  int pops_seen    = 0;
  int mismatches   = 0;
  int send_gap     = 0;
  int pop_gap      = 0;
  int hold_left    = 0;
  bit hold_done    = 1'b0;

  seven_segment_frame_builder_unit #(
    .NUM_CELLS(NUM_CELLS)
  ) uut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .command(command),
    .digit_index(digit_index),
    .digit_value(digit_value),
    .flag(flag),
    .dot_flags(dot_flags),
    .hours(hours),
    .minutes(minutes),
    .number(number),
    .level(level),
    .empty(empty),
    .pop(pop),
    .bus_address(bus_address),
    .data_byte(data_byte),
    .end_of_transaction(end_of_transaction),
    .last(last),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("[FAIL] regression broken");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic int cell_of(input logic [1:0] pos);
    return (pos > 2'd1) ? int'(pos) + 1 : int'(pos);
  endfunction

  function automatic logic [6:0] glyph(input logic [7:0] value);
    return (value <= 8'd9) ? GLYPHS[value] : 7'h00;
  endfunction

  task automatic place_digit(input logic [1:0] pos, input logic [7:0] value);
    int c;
    c = cell_of(pos);
    // the decimal point survives a digit change
    cell_model[c] = {cell_model[c][DP_BIT], glyph(value)};
  endtask

  task automatic show_pairs(input logic [7:0] left_pair, input logic [7:0] right_pair);
    foreach (cell_model[i]) cell_model[i] = 8'h00;
    place_digit(2'd0, left_pair / 8'd10);
    place_digit(2'd1, left_pair % 8'd10);
    place_digit(2'd2, right_pair / 8'd10);
    place_digit(2'd3, right_pair % 8'd10);
    cell_model[COLON_CELL][COLON_BIT] = 1'b1;
  endtask

  task automatic push_byte(input logic [7:0] value, input logic eot);
    byte_beat_t b;
    b.bus_address        = BASE_ADDR + 7'(offset_model);
    b.data_byte          = value;
    b.end_of_transaction = eot;
    b.last               = 1'b0;
    frame_bytes.push_back(b);
  endtask

  task automatic push_frame();
    push_byte(BYTE_PAD, 1'b0);
    for (int i = 0; i < NUM_CELLS; i++) begin
      push_byte(cell_model[i], 1'b0);
      push_byte(BYTE_PAD, i == NUM_CELLS - 1);
    end
  endtask

  task automatic predict_bus_bytes(input cmd_item_t it);
    logic [15:0] hundreds;
    logic [15:0] units;
    logic [3:0]  bright;
    logic [1:0]  rate;
    byte_beat_t  tail;
    frame_bytes.delete();
    hundreds = it.number / 16'd100;
    units    = it.number % 16'd100;
    bright   = (it.level > BRIGHT_MAX) ? BRIGHT_MAX : it.level[3:0];
    rate     = (it.level > BLINK_MAX) ? BLINK_MAX[1:0] : it.level[1:0];
    case (it.command)
      CMD_DIGIT:   place_digit(it.digit_index, it.digit_value);
      CMD_DECIMAL: cell_model[cell_of(it.digit_index)][DP_BIT] = it.flag;
      CMD_COLON:   cell_model[COLON_CELL][COLON_BIT] = it.flag;
      CMD_DOTS: begin
        cell_model[COLON_CELL][DOT_LL_BIT] = it.dot_flags[0];
        cell_model[COLON_CELL][DOT_UL_BIT] = it.dot_flags[1];
        cell_model[COLON_CELL][DOT_UR_BIT] = it.dot_flags[2];
      end
      CMD_CLOCK:   show_pairs(it.hours, it.minutes);
      CMD_NUMBER: begin
        // hundreds wrap at 8 bits, colon stays dark
        show_pairs(hundreds[7:0], units[7:0]);
        cell_model[COLON_CELL][COLON_BIT] = 1'b0;
      end
      CMD_CLEAR:   foreach (cell_model[i]) cell_model[i] = 8'h00;
      CMD_FILL:    foreach (cell_model[i]) cell_model[i] = 8'hFF;
      CMD_FLUSH:   push_frame();
      CMD_BRIGHT:  push_byte(BYTE_BRIGHT | {4'b0000, bright}, 1'b1);
      CMD_BLINK:   push_byte(BYTE_BLINK | {5'b00000, rate, 1'b0}, 1'b1);
      CMD_INIT: begin
        push_byte(BYTE_INIT, 1'b1);
        foreach (cell_model[i]) cell_model[i] = 8'h00;
        push_frame();
        push_byte(BYTE_BRIGHT | {4'b0000, BRIGHT_MAX}, 1'b1);
        push_byte(BYTE_BLINK, 1'b1);
      end
      default: ;
    endcase
    if (frame_bytes.size() != 0) begin
      tail = frame_bytes.pop_back();
      tail.last = 1'b1;
      frame_bytes.push_back(tail);
      foreach (frame_bytes[i]) expected_bytes.push_back(frame_bytes[i]);
    end
  endtask

  // ---------------------------------------------------------------- stimulus

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic cmd_item_t with_cmd(input logic [3:0] cmd);
    cmd_item_t it;
    it.command     = cmd;
    it.digit_index = 2'($urandom);
    it.digit_value = $urandom_range(0, 1) ? 8'($urandom_range(0, 11)) : 8'($urandom);
    it.flag        = 1'($urandom);
    it.dot_flags   = 3'($urandom);
    it.hours       = $urandom_range(0, 1) ? 8'($urandom_range(0, 23)) : 8'($urandom);
    it.minutes     = $urandom_range(0, 1) ? 8'($urandom_range(0, 59)) : 8'($urandom);
    it.number      = $urandom_range(0, 1) ? 16'($urandom_range(0, 9999)) : 16'($urandom);
    it.level       = $urandom_range(0, 1) ? 8'($urandom_range(0, 20)) : 8'($urandom);
    return it;
  endfunction

  // mostly buffer edits followed by flushes, some control bytes and spare codes
  function automatic cmd_item_t random_cmd();
    int r;
    logic [3:0] cmd;
    r = $urandom_range(0, 99);
    if (r < 20)      cmd = CMD_DIGIT;
    else if (r < 28) cmd = CMD_DECIMAL;
    else if (r < 32) cmd = CMD_COLON;
    else if (r < 36) cmd = CMD_DOTS;
    else if (r < 42) cmd = CMD_CLOCK;
    else if (r < 48) cmd = CMD_NUMBER;
    else if (r < 51) cmd = CMD_CLEAR;
    else if (r < 53) cmd = CMD_FILL;
    else if (r < 75) cmd = CMD_FLUSH;
    else if (r < 83) cmd = CMD_BRIGHT;
    else if (r < 91) cmd = CMD_BLINK;
    else if (r < 95) cmd = CMD_INIT;
    else             cmd = 4'($urandom_range(CMD_INIT + 1, CMD_SPARE_TOP));
    return with_cmd(cmd);
  endfunction

  task automatic load_offset(input logic [2:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    offset_model = value;
  endtask

  task automatic drain();
    while (pending_cmds.size() != 0 || push || expected_bytes.size() != 0) @(posedge clk);
    // edits produce no beat, so give the front time to finish them
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------- driver

  always @(negedge clk) begin
    logic      taken_now;
    cmd_item_t nxt;
    if (rst) begin
      push <= 1'b0;
    end else begin
      taken_now = push && (cmds_taken == cmds_offered);
      if (taken_now) send_gap = pick_gap();
      if (!push || taken_now) begin
        if (send_gap == 0 && pending_cmds.size() != 0) begin
          nxt = pending_cmds.pop_front();
          command     <= nxt.command;
          digit_index <= nxt.digit_index;
          digit_value <= nxt.digit_value;
          flag        <= nxt.flag;
          dot_flags   <= nxt.dot_flags;
          hours       <= nxt.hours;
          minutes     <= nxt.minutes;
          number      <= nxt.number;
          level       <= nxt.level;
          push        <= 1'b1;
          cmds_offered++;
        end else begin
          push <= 1'b0;
          if (send_gap > 0 && !taken_now) send_gap--;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      // one long stall while commands keep coming, so the block backs up
      if (!hold_done && cmds_taken >= HOLD_AT) begin
        hold_left = LONG_HOLD;
        hold_done = 1'b1;
      end
      if (bytes_popped != pops_seen) begin
        pops_seen = bytes_popped;
        pop_gap   = pick_gap();
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (pop_gap > 0) begin
        pop_gap--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- monitors

  always @(posedge clk) begin
    cmd_item_t seen;
    if (!rst && push && !full) begin
      seen = '{command, digit_index, digit_value, flag, dot_flags,
               hours, minutes, number, level};
      cmds_taken++;
      predict_bus_bytes(seen);
    end
  end

  task automatic report_beat(input string what, input byte_beat_t want,
                             input byte_beat_t got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("beat %0d %s: expected addr=%h data=%h eot=%b last=%b, got addr=%h data=%h eot=%b last=%b",
               bytes_popped, what, want.bus_address, want.data_byte,
               want.end_of_transaction, want.last, got.bus_address, got.data_byte,
               got.end_of_transaction, got.last);
  endtask

  always @(posedge clk) begin
    byte_beat_t got;
    byte_beat_t want;
    if (!rst && pop && !empty) begin
      got = '{bus_address, data_byte, end_of_transaction, last};
      if (expected_bytes.size() == 0) begin
        want = '{7'h00, 8'h00, 1'b0, 1'b0};
        report_beat("with nothing expected", want, got);
      end else begin
        want = expected_bytes.pop_front();
        if (got.bus_address !== want.bus_address || got.data_byte !== want.data_byte ||
            got.end_of_transaction !== want.end_of_transaction ||
            got.last !== want.last)
          report_beat("mismatch", want, got);
      end
      bytes_popped++;
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    cmd_item_t  it;
    logic [2:0] offsets [4];
    foreach (cell_model[i]) cell_model[i] = 8'h00;
    offset_model = 3'd0;
    offsets = '{3'd7, 3'($urandom_range(1, 6)), 3'd0, 3'd5};

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    load_offset(3'd0);

    // digits at every position, a blank above nine
    it = with_cmd(CMD_DIGIT); it.digit_index = 2'd0; it.digit_value = 8'd0;
    pending_cmds.push_back(it);
    it = with_cmd(CMD_DIGIT); it.digit_index = 2'd1; it.digit_value = 8'd9;
    pending_cmds.push_back(it);
    it = with_cmd(CMD_DIGIT); it.digit_index = 2'd2; it.digit_value = 8'd10;
    pending_cmds.push_back(it);
    // point set first, then the digit rewritten under it
    it = with_cmd(CMD_DECIMAL); it.digit_index = 2'd3; it.flag = 1'b1;
    pending_cmds.push_back(it);
    it = with_cmd(CMD_DIGIT); it.digit_index = 2'd3; it.digit_value = 8'd255;
    pending_cmds.push_back(it);
    it = with_cmd(CMD_COLON); it.flag = 1'b1;
    pending_cmds.push_back(it);
    it = with_cmd(CMD_DOTS); it.dot_flags = 3'd7;
    pending_cmds.push_back(it);
    pending_cmds.push_back(with_cmd(CMD_FLUSH));
    it = with_cmd(CMD_DOTS); it.dot_flags = 3'd2;
    pending_cmds.push_back(it);
    it = with_cmd(CMD_DECIMAL); it.digit_index = 2'd3; it.flag = 1'b0;
    pending_cmds.push_back(it);
    it = with_cmd(CMD_COLON); it.flag = 1'b0;
    pending_cmds.push_back(it);
    pending_cmds.push_back(with_cmd(CMD_FLUSH));
    it = with_cmd(CMD_CLOCK); it.hours = 8'd255; it.minutes = 8'd0;
    pending_cmds.push_back(it);
    pending_cmds.push_back(with_cmd(CMD_FLUSH));
    it = with_cmd(CMD_NUMBER); it.number = 16'hFFFF;
    pending_cmds.push_back(it);
    pending_cmds.push_back(with_cmd(CMD_FLUSH));
    pending_cmds.push_back(with_cmd(CMD_FILL));
    pending_cmds.push_back(with_cmd(CMD_FLUSH));
    pending_cmds.push_back(with_cmd(CMD_CLEAR));
    it = with_cmd(CMD_BRIGHT); it.level = 8'd0;
    pending_cmds.push_back(it);
    it = with_cmd(CMD_BRIGHT); it.level = 8'd255;
    pending_cmds.push_back(it);
    it = with_cmd(CMD_BLINK); it.level = 8'd3;
    pending_cmds.push_back(it);
    it = with_cmd(CMD_BLINK); it.level = 8'd255;
    pending_cmds.push_back(it);
    pending_cmds.push_back(with_cmd(CMD_INIT));
    pending_cmds.push_back(with_cmd(CMD_INIT + 4'd1));
    pending_cmds.push_back(with_cmd(CMD_SPARE_TOP));
    drain();

    foreach (offsets[p]) begin
      load_offset(offsets[p]);
      repeat (RANDOM_PER_PHASE) pending_cmds.push_back(random_cmd());
      drain();
    end

    if (mismatches == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
